// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GPBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define GPBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gpbs_pkg.sv =====
`timescale 1ns / 1ps

package gpbs_pkg;

    localparam int SIDE_MAX = 16;
    localparam int ROW_W    = 4;
    localparam int CELL_W   = 16;
    localparam int SIDE_W   = 5;
    localparam int STACK_D  = 31;
    localparam int TOP_W    = 5;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic DIR_RIGHT = 1'b0;
    localparam logic DIR_DOWN  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH_CUR,
        ST_FETCH_BELOW,
        ST_FETCH_UP,
        ST_STEP,
        ST_OUT
    } gpbs_state_t;

    typedef struct packed {
        logic              load_we;
        logic [ROW_W-1:0]  load_row;
        logic [CELL_W-1:0] load_cells;
        logic              work_clear;
        logic              work_we;
        logic [ROW_W-1:0]  work_row;
        logic [CELL_W-1:0] work_cells;
        logic [ROW_W-1:0]  rd_row;
    } gpbs_store_ctl_t;

endpackage

// ===== hdl/gpbs_row_store.sv =====
`timescale 1ns / 1ps

module gpbs_row_store
    import gpbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  gpbs_store_ctl_t   ctl,
    output logic [CELL_W-1:0] rd_open
);

    // loaded maze and working copy with dead cells removed
    logic [CELL_W-1:0]   maze_mem [SIDE_MAX];
    logic [CELL_W-1:0]   work_mem [SIDE_MAX];
    logic [SIDE_MAX-1:0] maze_vld_reg;
    logic [SIDE_MAX-1:0] work_vld_reg;
    logic [CELL_W-1:0]   maze_q_reg;
    logic [CELL_W-1:0]   work_q_reg;
    logic                maze_vq_reg;
    logic                work_vq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maze_vld_reg <= '0;
            work_vld_reg <= '0;
        end
        else
        begin
            if (ctl.load_we)
            begin
                maze_vld_reg[ctl.load_row] <= 1'b1;
            end
            if (ctl.work_clear)
            begin
                work_vld_reg <= '0;
            end
            else if (ctl.work_we)
            begin
                work_vld_reg[ctl.work_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_we)
        begin
            maze_mem[ctl.load_row] <= ctl.load_cells;
        end
        if (ctl.work_we)
        begin
            work_mem[ctl.work_row] <= ctl.work_cells;
        end
        maze_q_reg  <= maze_mem[ctl.rd_row];
        work_q_reg  <= work_mem[ctl.rd_row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maze_vq_reg <= 1'b0;
            work_vq_reg <= 1'b0;
        end
        else
        begin
            maze_vq_reg <= maze_vld_reg[ctl.rd_row];
            work_vq_reg <= work_vld_reg[ctl.rd_row] && !ctl.work_clear;
        end
    end

    always_comb
    begin
        if (work_vq_reg)
        begin
            rd_open = work_q_reg;
        end
        else if (maze_vq_reg)
        begin
            rd_open = maze_q_reg;
        end
        else
        begin
            rd_open = '0;
        end
    end

endmodule

// ===== hdl/grid_path_backtrack_search.sv =====
`timescale 1ns / 1ps
// Maze path search, right-first depth-first search with backtracking.
// Input stream: tuser selects a row load (0) or a search (1). A load beat writes
// row_index with its open-cell mask and produces no result.
// A search runs from the top-left to the bottom-right cell of a square of
// grid_side cells, written beforehand through the config channel (5 bits).
// Search time depends on the maze: right moves and sideways backtracks stay in
// the step state, while down moves and upward backtracks wait on a read of the
// row memory, since every row change costs one read. Dead cells are remembered,
// so no cell is entered twice.
// Output stream: one beat per path row (tuser = found = 1, tlast on the final
// row), or a single beat with found 0 when no path exists.
// Input is not taken while a search runs or its results are pending; when
// the receiver stalls, the current output beat holds until taken.
// Reset: maze all blocked, side 4, no search pending.
// Config writes are taken at any time but belong only in idle periods.

module grid_path_backtrack_search
    import gpbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,       // grid_side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // row_index, row_cells, zero pad
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_row, path_cells, zero pad
    output logic        m_axis_tuser,   // found
    output logic        m_axis_tlast
);

    `include "assert_macros.svh"

    gpbs_state_t state_reg, state_next;

    logic [SIDE_W-1:0]  side_reg;
    logic [ROW_W-1:0]   last_idx_reg, last_idx_next;
    logic [ROW_W-1:0]   r_reg, r_next;
    logic [ROW_W-1:0]   c_reg, c_next;
    logic [TOP_W-1:0]   top_reg, top_next;
    logic [STACK_D-1:0] dir_reg, dir_next;
    logic [CELL_W-1:0]  cur_reg, cur_next;
    logic [CELL_W-1:0]  below_reg, below_next;
    logic [ROW_W-1:0]   k_reg, k_next;
    logic               found_reg, found_next;

    logic [SIDE_MAX-1:0][CELL_W-1:0] path_mark_reg;

    gpbs_store_ctl_t   ctl;
    logic [CELL_W-1:0] rd_open;

    logic              in_beat;
    logic              out_beat;
    logic [ROW_W-1:0]  side_last;
    logic [SIDE_W-1:0] side_m1;
    logic [ROW_W-1:0]  r_inc;
    logic [ROW_W-1:0]  c_inc;
    logic [CELL_W-1:0] c_bit;
    logic              at_goal;
    logic              right_ok;
    logic              down_ok;
    logic              mark_init;
    logic              mark_set;
    logic              mark_clr;
    logic [ROW_W-1:0]  mark_row;
    logic [ROW_W-1:0]  mark_col;

    gpbs_row_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_open (rd_open)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = m_axis_tvalid && m_axis_tready;

    assign m_axis_tuser = found_reg;
    assign m_axis_tlast = !found_reg || (k_reg == last_idx_reg);
    assign m_axis_tdata = {4'b0000,
                           (found_reg ? path_mark_reg[k_reg] : {CELL_W{1'b0}}),
                           k_reg};

    // out-of-range side clamps to 1..16
    assign side_m1   = side_reg - SIDE_W'(1);
    assign side_last = (side_reg == '0) ? '0 :
                       (side_reg > SIDE_W'(SIDE_MAX)) ? ROW_W'(SIDE_MAX - 1) :
                       side_m1[ROW_W-1:0];

    assign r_inc    = r_reg + ROW_W'(1);
    assign c_inc    = c_reg + ROW_W'(1);
    assign c_bit    = CELL_W'(1) << c_reg;
    assign at_goal  = (r_reg == last_idx_reg) && (c_reg == last_idx_reg);
    assign right_ok = (c_reg < last_idx_reg) && cur_reg[c_inc];
    assign down_ok  = (r_reg < last_idx_reg) && below_reg[c_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_W'(4);
        end
        else if (cfg_valid && cfg_ready)
        begin
            side_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            last_idx_reg <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            top_reg      <= '0;
            dir_reg      <= '0;
            k_reg        <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            last_idx_reg <= last_idx_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            top_reg      <= top_next;
            dir_reg      <= dir_next;
            k_reg        <= k_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        below_reg <= below_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_mark_reg <= '0;
        end
        else if (mark_init)
        begin
            path_mark_reg <= {{(SIDE_MAX * CELL_W - 1){1'b0}}, 1'b1};
        end
        else if (mark_set)
        begin
            path_mark_reg[mark_row][mark_col] <= 1'b1;
        end
        else if (mark_clr)
        begin
            path_mark_reg[mark_row][mark_col] <= 1'b0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        last_idx_next = last_idx_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        top_next      = top_reg;
        dir_next      = dir_reg;
        cur_next      = cur_reg;
        below_next    = below_reg;
        k_next        = k_reg;
        found_next    = found_reg;
        mark_init     = 1'b0;
        mark_set      = 1'b0;
        mark_clr      = 1'b0;
        mark_row      = r_reg;
        mark_col      = c_reg;
        ctl           = '0;
        ctl.rd_row    = r_reg;
        ctl.load_row  = s_axis_tdata[3:0];
        ctl.load_cells = s_axis_tdata[19:4];
        ctl.work_row  = r_reg;
        ctl.work_cells = cur_reg & ~c_bit;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (s_axis_tuser == OP_SEARCH)
                    begin
                        r_next         = '0;
                        c_next         = '0;
                        top_next       = '0;
                        found_next     = 1'b0;
                        last_idx_next  = side_last;
                        mark_init      = 1'b1;
                        ctl.work_clear = 1'b1;
                        ctl.rd_row     = '0;
                        state_next     = ST_FETCH_CUR;
                    end
                    else
                    begin
                        ctl.load_we = 1'b1;
                    end
                end
            end
            ST_FETCH_CUR:
            begin
                cur_next   = rd_open;
                ctl.rd_row = r_inc;
                state_next = ST_FETCH_BELOW;
            end
            ST_FETCH_BELOW:
            begin
                below_next = rd_open;
                state_next = ST_STEP;
            end
            ST_FETCH_UP:
            begin
                cur_next   = rd_open;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (at_goal)
                begin
                    found_next = 1'b1;
                    k_next     = '0;
                    state_next = ST_OUT;
                end
                else if (right_ok)
                begin
                    c_next   = c_inc;
                    top_next = top_reg + TOP_W'(1);
                    dir_next = {dir_reg[STACK_D-2:0], DIR_RIGHT};
                    mark_set = 1'b1;
                    mark_col = c_inc;
                end
                else if (down_ok)
                begin
                    r_next     = r_inc;
                    cur_next   = below_reg;
                    top_next   = top_reg + TOP_W'(1);
                    dir_next   = {dir_reg[STACK_D-2:0], DIR_DOWN};
                    mark_set   = 1'b1;
                    mark_row   = r_inc;
                    ctl.rd_row = r_inc + ROW_W'(1);
                    state_next = ST_FETCH_BELOW;
                end
                else
                begin
                    // dead end: drop cell from working maze; back up, or no path
                    mark_clr    = 1'b1;
                    ctl.work_we = 1'b1;
                    if (top_reg == '0)
                    begin
                        found_next = 1'b0;
                        k_next     = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        top_next = top_reg - TOP_W'(1);
                        dir_next = {1'b0, dir_reg[STACK_D-1:1]};
                        if (dir_reg[0] == DIR_DOWN)
                        begin
                            r_next     = r_reg - ROW_W'(1);
                            below_next = cur_reg & ~c_bit;
                            ctl.rd_row = r_reg - ROW_W'(1);
                            state_next = ST_FETCH_UP;
                        end
                        else
                        begin
                            c_next   = c_reg - ROW_W'(1);
                            cur_next = cur_reg & ~c_bit;
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (out_beat)
                begin
                    if (m_axis_tlast)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + ROW_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `GPBS_ASSERT_SAME(a_one_side_busy, s_axis_tready, !m_axis_tvalid,
        "input taken while results pending")
    `GPBS_ASSERT_SAME(a_stack_bound, state_reg == ST_STEP, top_reg <= TOP_W'(STACK_D - 1),
        "move stack overflow")
    `GPBS_ASSERT_SAME(a_cur_marked, state_reg == ST_STEP, path_mark_reg[r_reg][c_reg],
        "current cell not on path")
    `GPBS_ASSERT_SAME(a_miss_single, m_axis_tvalid && !m_axis_tuser, m_axis_tlast,
        "not-found result not final")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import gpbs_pkg::*;

    localparam int STALL_LIMIT = 6000;
    localparam int ITEM_GOAL   = 350;

    typedef struct {
        logic        found;
        logic [3:0]  row;
        logic [15:0] cells;
        logic        tail;
    } path_beat_t;

    class path_scoreboard;
        logic [15:0] maze [16];
        logic [4:0]  side_reg;
        path_beat_t  expected_rows [$];
        int          errors;
        int          loads;
        int          searches;
        int          hits;
        int          misses;
        int          beats_checked;

        function new();
            foreach (maze[i])
            begin
                maze[i] = '0;
            end
            side_reg      = 5'd4;
            errors        = 0;
            loads         = 0;
            searches      = 0;
            hits          = 0;
            misses        = 0;
            beats_checked = 0;
        endfunction

        function void queue_row(path_beat_t b);
            expected_rows = {expected_rows, b};
        endfunction

        // right-first walk along cells from which the goal stays reachable
        function void trace_path();
            logic [15:0] reach [16];
            logic [15:0] mark [16];
            path_beat_t  b;
            int          s;
            int          r;
            int          c;
            s = side_reg;
            if (s < 1)
                s = 1;
            if (s > SIDE_MAX)
                s = SIDE_MAX;
            foreach (reach[i])
            begin
                reach[i] = '0;
                mark[i]  = '0;
            end
            for (r = s - 1; r >= 0; r--)
            begin
                for (c = s - 1; c >= 0; c--)
                begin
                    if ((r == s - 1 && c == s - 1) ||
                        (c + 1 < s && maze[r][c+1] && reach[r][c+1]) ||
                        (r + 1 < s && maze[r+1][c] && reach[r+1][c]))
                        reach[r][c] = 1'b1;
                end
            end
            searches++;
            if (!reach[0][0])
            begin
                misses++;
                b = '{1'b0, 4'd0, 16'd0, 1'b1};
                queue_row(b);
                return;
            end
            hits++;
            r = 0;
            c = 0;
            mark[0][0] = 1'b1;
            while (!(r == s - 1 && c == s - 1))
            begin
                if (c + 1 < s && maze[r][c+1] && reach[r][c+1])
                    c++;
                else
                    r++;
                mark[r][c] = 1'b1;
            end
            for (r = 0; r < s; r++)
            begin
                b = '{1'b1, 4'(r), mark[r], (r == s - 1)};
                queue_row(b);
            end
        endfunction

        function void note_beat_in(logic op, logic [3:0] row, logic [15:0] cells);
            if (op == OP_LOAD)
            begin
                maze[row] = cells;
                loads++;
            end
            else
                trace_path();
        endfunction

        function void check_beat_out(logic found, logic [3:0] row, logic [15:0] cells,
                                     logic tail);
            path_beat_t e;
            if (expected_rows.size() == 0)
            begin
                $error("unexpected result beat: found %0d row %0d cells %h", found, row, cells);
                errors++;
                return;
            end
            e = expected_rows.pop_front();
            beats_checked++;
            if (found !== e.found)
            begin
                $error("found: expected %0d, got %0d", e.found, found);
                errors++;
            end
            if (row !== e.row)
            begin
                $error("out_row: expected %0d, got %0d", e.row, row);
                errors++;
            end
            if (cells !== e.cells)
            begin
                $error("path_cells: expected %h, got %h", e.cells, cells);
                errors++;
            end
            if (tail !== e.tail)
            begin
                $error("last: expected %0d, got %0d", e.tail, tail);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    path_scoreboard sb = new();

    int burst_left = 0;
    bit in_burst = 0;
    int n_items = 0;
    int n_cfg = 0;
    int rx_mode = 0;
    int rx_hold = 0;
    int quiet = 0;

    grid_path_backtrack_search i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (rx_mode == 0)
            m_axis_tready <= 1'b1;
        else if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 9) < (rx_mode == 1 ? 2 : 5))
                rx_hold <= $urandom_range(1, 7);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat_out(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4],
                              m_axis_tlast);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_beat(input logic op, input logic [3:0] row, input logic [15:0] cells);
        if (!in_burst)
        begin
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
            in_burst = 1;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'd0, cells, row};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_beat_in(op, row, cells);
        n_items++;
        burst_left--;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            in_burst = 0;
        end
    endtask

    task automatic search();
        send_beat(OP_SEARCH, 4'($urandom), 16'($urandom));
    endtask

    task automatic stop_input();
        if (in_burst)
        begin
            s_axis_tvalid <= 1'b0;
            in_burst = 0;
        end
    endtask

    task automatic drain();
        stop_input();
        @(posedge clk);
        while (sb.expected_rows.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_side(input logic [4:0] v);
        drain();
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.side_reg = v;
        n_cfg++;
    endtask

    // density modes: half open, mostly open, nearly open, random staircase plus noise
    task automatic send_maze(input int s, input int mode);
        logic [15:0] rows [16];
        int          r;
        int          c;
        for (r = 0; r < 16; r++)
        begin
            case (mode)
                0:       rows[r] = 16'($urandom);
                1:       rows[r] = 16'($urandom | $urandom);
                2:       rows[r] = 16'($urandom | $urandom | $urandom);
                default: rows[r] = 16'($urandom & $urandom);
            endcase
        end
        if (mode == 3)
        begin
            r = 0;
            c = 0;
            while (!(r == s - 1 && c == s - 1))
            begin
                if (r == s - 1 || (c < s - 1 && $urandom_range(0, 1) == 1))
                    c++;
                else
                    r++;
                rows[r][c] = 1'b1;
            end
        end
        for (r = 0; r < s; r++)
            send_beat(OP_LOAD, 4'(r), rows[r]);
    endtask

    initial
    begin
        int v;
        int eff;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, side 4 out of reset
        search();
        send_beat(OP_LOAD, 4'd0, 16'hFFFF);
        send_beat(OP_LOAD, 4'd1, 16'hFFFF);
        send_beat(OP_LOAD, 4'd2, 16'hFFFF);
        send_beat(OP_LOAD, 4'd3, 16'hFFFF);
        send_beat(OP_LOAD, 4'd15, 16'hFFFF);
        search();
        send_beat(OP_LOAD, 4'd0, 16'hFFFE);   // start cell closed
        search();
        send_beat(OP_LOAD, 4'd0, 16'h0001);   // right blocked at once
        search();
        send_beat(OP_LOAD, 4'd3, 16'h0000);   // goal row closed
        search();
        write_side(5'd1);
        search();
        write_side(5'd0);
        search();
        write_side(5'd31);
        search();

        while (n_items < ITEM_GOAL)
        begin
            case ($urandom_range(0, 9))
                0:       v = 16;
                1:       v = $urandom_range(17, 31);
                2:       v = $urandom_range(0, 1);
                default: v = $urandom_range(2, 10);
            endcase
            eff = (v == 0) ? 1 : (v > 16) ? 16 : v;
            write_side(5'(v));
            rx_mode = $urandom_range(0, 2);
            repeat ($urandom_range(2, 4))
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    send_maze(eff, $urandom_range(0, 3));
                    search();
                    if ($urandom_range(0, 1) == 1)
                    begin
                        send_beat(OP_LOAD, 4'($urandom_range(0, eff - 1)), 16'($urandom));
                        search();
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 5))
                        send_beat(OP_LOAD, 4'($urandom_range(0, 15)), 16'($urandom));
                    search();
                end
            end
        end

        drain();
        repeat (50) @(posedge clk);
        sb.errors += sb.expected_rows.size();
        $display("run covered %0d input beats: %0d row loads, %0d searches",
                 n_items, sb.loads, sb.searches);
        $display("%0d paths, %0d dead ends, %0d result beats checked over %0d side settings",
                 sb.hits, sb.misses, sb.beats_checked, n_cfg);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== grid_path_backtrack_search.f =====
+incdir+hdl
hdl/gpbs_pkg.sv
hdl/gpbs_row_store.sv
hdl/grid_path_backtrack_search.sv
tb/sv/tb.sv
